FILE: hw/rtl/lfsta_pkg.sv
package lfsta_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_SLOTS_DEF = 64;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths of the request and result beats
  localparam int TIME_IN_W = 16;
  localparam int SLOT_W    = 6;

  // Register file: paddr is a byte address, bit 2 selects the register
  localparam int  APB_ADDR_W = 3;
  localparam int  APB_DATA_W = 32;
  localparam logic REG_TARGET = 1'b0;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture request, restart the sweep
    logic step;   // read one table entry and advance the pointer
    logic clear;  // clearing pass: write an empty entry and advance
    logic emit;   // register the result beat
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;   // pointer sits on the highest slot
  } dp_stat_t;

endpackage

FILE: hw/rtl/lowest_free_slot_timed_allocator_top.sv
// Lowest-free-slot allocator with timed release. A request beat is taken at
// a clock edge with start high and busy low; it carries first_of_set,
// arrival_time and leave_time. The block frees every held slot whose release
// time is at or before the arrival (all slots when first_of_set is set),
// grants the lowest free slot and stores leave_time as its release time.
// Exactly one result beat follows per request: res_valid_o is high for one
// cycle with slot_o, is_target_o and full_res_o, and there is no way to hold
// it off, so the receiver must take it in that cycle. When no slot is free,
// full_res_o is 1, slot_o is 0 and nothing is stored. A new request is taken
// only once the last is through. The slot table sits in a single-port-read
// memory and each request sweeps it once, one entry per cycle, writing back the
// updated busy bit in the cycle after the read; the result beat shows in the
// cycle busy drops, and the next request can be taken in that same cycle. After
// reset a clearing pass empties every entry of the table while busy is high.
// target_arrival sits at byte address 0 of the APB port (address 4 is
// unmapped, reads 0, ignores writes); change it only while idle.
module lowest_free_slot_timed_allocator_top #(
  parameter int NUM_SLOTS = lfsta_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = lfsta_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request
  input  logic                             start,
  output logic                             busy,
  input  logic                             first_of_set_i,
  input  logic [lfsta_pkg::TIME_IN_W-1:0]  arrival_time_i,
  input  logic [lfsta_pkg::TIME_IN_W-1:0]  leave_time_i,
  // Result
  output logic                             res_valid_o,
  output logic [lfsta_pkg::SLOT_W-1:0]     slot_o,
  output logic                             is_target_o,
  output logic                             full_res_o,
  // APB register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfsta_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lfsta_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lfsta_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import lfsta_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [TIME_IN_W-1:0] target_q;
  logic                 reg_sel;

  // Register decode: bit 2 of the byte address picks the register
  assign reg_sel = (paddr[2] == REG_TARGET);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      target_q <= pwdata[TIME_IN_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(target_q) : '0;

  lfsta_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  lfsta_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .first_of_set_i   (first_of_set_i),
    .arrival_time_i   (arrival_time_i),
    .leave_time_i     (leave_time_i),
    .target_arrival_i (target_q),
    .res_valid_o      (res_valid_o),
    .slot_o           (slot_o),
    .is_target_o      (is_target_o),
    .full_res_o       (full_res_o)
  );

endmodule

FILE: hw/rtl/lfsta_ctrl.sv
module lfsta_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output lfsta_pkg::dp_cmd_t  cmd_o,
  input  lfsta_pkg::dp_stat_t stat_i
);
  import lfsta_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (stat_i.last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cmd_o.load  = (state_q == ST_IDLE) && start_i;
  assign cmd_o.step  = (state_q == ST_SWEEP);
  assign cmd_o.clear = (state_q == ST_CLEAR);
  assign cmd_o.emit  = (state_q == ST_DRAIN);

endmodule

FILE: hw/rtl/lfsta_dp.sv
module lfsta_dp #(
  parameter int NUM_SLOTS = lfsta_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = lfsta_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfsta_pkg::dp_cmd_t             cmd_i,
  output lfsta_pkg::dp_stat_t            stat_o,
  input  logic                           first_of_set_i,
  input  logic [lfsta_pkg::TIME_IN_W-1:0] arrival_time_i,
  input  logic [lfsta_pkg::TIME_IN_W-1:0] leave_time_i,
  input  logic [lfsta_pkg::TIME_IN_W-1:0] target_arrival_i,
  output logic                           res_valid_o,
  output logic [lfsta_pkg::SLOT_W-1:0]   slot_o,
  output logic                           is_target_o,
  output logic                           full_res_o
);
  import lfsta_pkg::*;

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int WORD_W = TIME_BITS + 1;   // {busy, release time}

  // Slot table
  logic [WORD_W-1:0] mem_q [NUM_SLOTS];

  logic [IDX_W-1:0]     addr_q;
  logic                 last;

  // Request registers
  logic                 first_q;
  logic [TIME_BITS-1:0] arr_q;
  logic [TIME_BITS-1:0] leave_q;
  logic                 hit_q;

  // Read stage
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [WORD_W-1:0]    rd_data_q;

  // Update stage
  logic                 busy_rel;
  logic                 grant_here;
  logic [WORD_W-1:0]    wr_data;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     slot_q, slot_d;

  // Result beat
  logic                 res_valid_q;
  logic [SLOT_W-1:0]    slot_res_q;
  logic                 is_target_q;
  logic                 full_q;

  assign last        = (addr_q == IDX_W'(NUM_SLOTS - 1));
  assign stat_o.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.step || cmd_i.clear) begin
      addr_q <= last ? '0 : addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q <= first_of_set_i;
      arr_q   <= TIME_BITS'(arrival_time_i);
      leave_q <= TIME_BITS'(leave_time_i);
      hit_q   <= (arrival_time_i == target_arrival_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_data_q <= mem_q[addr_q];
      rd_idx_q  <= addr_q;
    end
  end

  // Release check and first-free pick for the entry just read
  always_comb begin
    busy_rel   = rd_data_q[TIME_BITS] && !first_q &&
                 !(rd_data_q[TIME_BITS-1:0] <= arr_q);
    grant_here = rd_vld_q && !busy_rel && !found_q;
    wr_data    = grant_here ? {1'b1, leave_q} : {busy_rel, rd_data_q[TIME_BITS-1:0]};
    found_d    = found_q || grant_here;
    slot_d     = grant_here ? rd_idx_q : slot_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[addr_q] <= '0;
    end else if (rd_vld_q) begin
      mem_q[rd_idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      slot_res_q  <= found_d ? SLOT_W'(slot_d) : '0;
      is_target_q <= hit_q;
      full_q      <= !found_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign slot_o      = slot_res_q;
  assign is_target_o = is_target_q;
  assign full_res_o  = full_q;

endmodule

FILE: hw/rtl/lfsta_chk.sv
module lfsta_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             res_valid_o,
  input logic [lfsta_pkg::SLOT_W-1:0]     slot_o,
  input logic                             full_res_o
);

  // A taken request keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Result beats are single-cycle and isolated
  a_beat_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held over two cycles");

  // A result shows only once the block has gone idle
  a_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy)))
    else $error("result beat outside the end of a request");

  // Full result reports slot zero
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && full_res_o) |-> (slot_o == '0))
    else $error("full result with nonzero slot");

endmodule

bind lowest_free_slot_timed_allocator_top lfsta_chk u_lfsta_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .slot_o      (slot_o),
  .full_res_o  (full_res_o)
);
